// ===== sv/cfd_pkg.sv =====
package cfd_pkg;

    localparam int MAX_DELIM_BYTES  = 4;
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int QUEUE_DEPTH      = 2;

    // register indexes
    localparam logic [2:0] REG_START_PATTERN = 3'd0;
    localparam logic [2:0] REG_START_COUNT   = 3'd1;
    localparam logic [2:0] REG_END_PATTERN   = 3'd2;
    localparam logic [2:0] REG_END_COUNT     = 3'd3;
    localparam logic [2:0] REG_ESCAPE_XOR    = 3'd4;
    localparam logic [2:0] REG_LENGTH_FORMAT = 3'd5;
    localparam logic [2:0] REG_MAX_FRAME     = 3'd6;
    localparam logic [2:0] REG_TIMEOUT       = 3'd7;

    localparam logic [15:0] MAX_FRAME_RESET = 16'd4096;

    // input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] RK_BYTE  = 2'd0;
    localparam logic [1:0] RK_DONE  = 2'd1;
    localparam logic [1:0] RK_ABORT = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OVERLEN = 2'd1;
    localparam logic [1:0] ERR_BADLEN  = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_IN_FRAME  = 3'd1,
        PH_ESCAPE    = 3'd2,
        PH_LENGTH    = 3'd3,
        PH_AWAIT_END = 3'd4
    } phase_t;

    // what follows the bytes of an item once they all fit
    typedef enum logic [1:0] {
        AF_NONE,
        AF_LEN,
        AF_CHK,
        AF_DONE
    } after_t;

    typedef struct packed {
        logic [31:0] start_pattern;
        logic [2:0]  start_count;
        logic [31:0] end_pattern;
        logic [2:0]  end_count;
        logic [15:0] escape_and_xor;
        logic [11:0] length_format;
        logic [15:0] max_frame_bytes;
        logic [31:0] timeout_ticks;
    } cfg_t;

    // one item's worth of results: nb frame bytes (first k from pat, then extra),
    // then an optional terminal result
    typedef struct packed {
        logic [31:0] pat;
        logic [2:0]  k;
        logic [7:0]  extra;
        logic [2:0]  nb;
        logic [15:0] base;
        logic [1:0]  term;
        logic [1:0]  err;
    } cmd_t;

    function automatic logic [2:0] clamp_cnt(input logic [2:0] c);
        logic [2:0] r;
        r = c;
        if (r > 3'(MAX_DELIM_BYTES)) r = 3'(MAX_DELIM_BYTES);
        return r;
    endfunction

    function automatic logic [2:0] clamp_len(input logic [2:0] c);
        logic [2:0] r;
        r = c;
        if (r > 3'(MAX_LENGTH_BYTES)) r = 3'(MAX_LENGTH_BYTES);
        return r;
    endfunction

    function automatic logic [7:0] pat_byte(input logic [31:0] p, input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0: r = p[7:0];
            2'd1: r = p[15:8];
            2'd2: r = p[23:16];
            default: r = p[31:24];
        endcase
        return r;
    endfunction

endpackage

// ===== sv/configurable_frame_deframer_top.sv =====
// Byte-serial frame parser. Each input item is a received byte or one timer
// tick; each accepted frame byte comes out as its own result item (already
// unescaped), and a frame closes with a complete or abort item. Frames open on
// an optional start delimiter and end on an end delimiter or a length field.
// Input items are taken one per cycle while the queue is not full: the front
// end updates the parse state in the cycle it accepts an item and queues a
// compact description of that item's results. The back end expands each
// description into results, one per cycle while m_tready allows (an item
// gives N results, N = 1..5); the 2-entry queue lets the input keep flowing
// meanwhile. Items that give no result (delimiter bytes still matching, escape
// bytes, most ticks) are not queued. Write configuration only while idle.
module configurable_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // kind: 0 byte, 1 tick
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // frame_byte[7:0], error_code[9:8], frame_length[25:10]
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast,   // last result of the item
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cfd_pkg::cfg_t cfg_reg;
    cfd_pkg::cmd_t push_cmd, head;
    logic push, pop, full, empty;

    // configuration registers, out-of-width bits dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{start_pattern:   32'd0,
                         start_count:     3'd0,
                         end_pattern:     32'd0,
                         end_count:       3'd0,
                         escape_and_xor:  16'd0,
                         length_format:   12'd0,
                         max_frame_bytes: cfd_pkg::MAX_FRAME_RESET,
                         timeout_ticks:   32'd0};
        end else if (cfg_we) begin
            case (cfg_index)
                cfd_pkg::REG_START_PATTERN: cfg_reg.start_pattern   <= cfg_wdata;
                cfd_pkg::REG_START_COUNT:   cfg_reg.start_count     <= cfg_wdata[2:0];
                cfd_pkg::REG_END_PATTERN:   cfg_reg.end_pattern     <= cfg_wdata;
                cfd_pkg::REG_END_COUNT:     cfg_reg.end_count       <= cfg_wdata[2:0];
                cfd_pkg::REG_ESCAPE_XOR:    cfg_reg.escape_and_xor  <= cfg_wdata[15:0];
                cfd_pkg::REG_LENGTH_FORMAT: cfg_reg.length_format   <= cfg_wdata[11:0];
                cfd_pkg::REG_MAX_FRAME:     cfg_reg.max_frame_bytes <= cfg_wdata[15:0];
                cfd_pkg::REG_TIMEOUT:       cfg_reg.timeout_ticks   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: parse state, one item per cycle unless the queue is full
    cfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_byte  (s_tdata),
        .q_full   (full),
        .in_ready (s_tready),
        .push     (push),
        .cmd      (push_cmd)
    );

    cfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    // back: one result per cycle into the output register while the output is not held
    cfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sv/cfd_front.sv =====
module cfd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfd_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  logic          in_kind,
    input  logic [7:0]    in_byte,
    input  logic          q_full,
    output logic          in_ready,
    output logic          push,
    output cfd_pkg::cmd_t cmd
);

    cfd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  smp_reg, smp_next;
    logic [2:0]  emp_reg, emp_next;
    logic [15:0] fc_reg, fc_next;
    logic [2:0]  lbs_reg, lbs_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [15:0] exp_reg, exp_next;
    logic [31:0] itc_reg, itc_next;

    logic acc, has_res;

    assign in_ready = !q_full;
    assign acc      = in_valid && !q_full;
    assign push     = acc && has_res;

    always_comb begin
        logic [2:0]  sc, ec, ls, want_k, want, lbs_in, lbs_new;
        logic        want_x, do_bytes, clr, infr, le;
        logic [7:0]  esc, off, x_byte;
        logic [31:0] pat, lacc_in, lacc_new, itc_inc;
        logic [16:0] fc_new;
        cfd_pkg::after_t after;

        sc  = cfd_pkg::clamp_cnt(cfg.start_count);
        ec  = cfd_pkg::clamp_cnt(cfg.end_count);
        ls  = cfd_pkg::clamp_len(cfg.length_format[10:8]);
        esc = cfg.escape_and_xor[15:8];
        off = cfg.length_format[7:0];
        le  = cfg.length_format[11];

        phase_next = phase_reg;
        smp_next   = smp_reg;
        emp_next   = emp_reg;
        fc_next    = fc_reg;
        lbs_next   = lbs_reg;
        lacc_next  = lacc_reg;
        exp_next   = exp_reg;
        itc_next   = itc_reg;

        has_res  = 1'b0;
        cmd      = '0;
        cmd.base = fc_reg;
        cmd.term = cfd_pkg::RK_BYTE;
        cmd.err  = cfd_pkg::ERR_NONE;

        want_k   = '0;
        want_x   = 1'b0;
        want     = '0;
        x_byte   = in_byte;
        pat      = '0;
        after    = cfd_pkg::AF_NONE;
        do_bytes = 1'b0;
        clr      = 1'b0;
        infr     = 1'b0;
        lacc_in  = lacc_reg;
        lbs_in   = lbs_reg;
        lacc_new = '0;
        lbs_new  = '0;
        fc_new   = '0;
        itc_inc  = '0;

        if (in_kind == cfd_pkg::KIND_TICK) begin
            if (phase_reg != cfd_pkg::PH_IDLE && cfg.timeout_ticks != '0) begin
                itc_inc  = (itc_reg == '1) ? itc_reg : itc_reg + 32'd1;
                itc_next = itc_inc;
                if (itc_inc >= cfg.timeout_ticks) begin
                    has_res  = 1'b1;
                    cmd.term = cfd_pkg::RK_ABORT;
                    cmd.err  = cfd_pkg::ERR_TIMEOUT;
                    clr      = 1'b1;
                end
            end
        end else begin
            if (phase_reg != cfd_pkg::PH_IDLE) itc_next = '0;
            case (phase_reg)
                cfd_pkg::PH_IDLE: begin
                    if (sc == '0) begin
                        smp_next   = '0;
                        phase_next = cfd_pkg::PH_IN_FRAME;
                        do_bytes   = 1'b1;
                        want_x     = 1'b1;
                    end else if (smp_reg < sc &&
                                 in_byte == cfd_pkg::pat_byte(cfg.start_pattern,
                                                              smp_reg[1:0])) begin
                        if (smp_reg + 3'd1 >= sc) begin
                            smp_next   = '0;
                            phase_next = cfd_pkg::PH_IN_FRAME;
                            do_bytes   = 1'b1;
                            pat        = cfg.start_pattern;
                            want_k     = sc;
                        end else begin
                            smp_next = smp_reg + 3'd1;
                        end
                    end else begin
                        smp_next = '0;
                    end
                end
                cfd_pkg::PH_ESCAPE: begin
                    phase_next = cfd_pkg::PH_IN_FRAME;
                    do_bytes   = 1'b1;
                    want_x     = 1'b1;
                    x_byte     = in_byte ^ cfg.escape_and_xor[7:0];
                    after      = cfd_pkg::AF_CHK;
                end
                cfd_pkg::PH_LENGTH: begin
                    do_bytes = 1'b1;
                    want_x   = 1'b1;
                    after    = cfd_pkg::AF_LEN;
                end
                default: begin
                    infr = (phase_reg == cfd_pkg::PH_IN_FRAME);
                    if (esc != '0 && in_byte == esc) begin
                        phase_next = cfd_pkg::PH_ESCAPE;
                    end else if (infr && ls != '0 && fc_reg == {8'd0, off} &&
                                 exp_reg == '0) begin
                        phase_next = cfd_pkg::PH_LENGTH;
                        lbs_in     = '0;
                        lacc_in    = '0;
                        do_bytes   = 1'b1;
                        want_x     = 1'b1;
                        after      = cfd_pkg::AF_LEN;
                    end else if (emp_reg < ec &&
                                 in_byte == cfd_pkg::pat_byte(cfg.end_pattern,
                                                              emp_reg[1:0])) begin
                        if (emp_reg + 3'd1 >= ec) begin
                            emp_next = '0;
                            do_bytes = 1'b1;
                            pat      = cfg.end_pattern;
                            want_k   = ec;
                            after    = cfd_pkg::AF_DONE;
                        end else begin
                            emp_next = emp_reg + 3'd1;
                        end
                    end else begin
                        // partial end match falls back into the payload
                        emp_next = '0;
                        do_bytes = 1'b1;
                        pat      = cfg.end_pattern;
                        want_k   = emp_reg;
                        want_x   = 1'b1;
                        after    = infr ? cfd_pkg::AF_CHK : cfd_pkg::AF_NONE;
                    end
                end
            endcase
        end

        if (do_bytes) begin
            want      = want_k + {2'd0, want_x};
            has_res   = 1'b1;
            cmd.pat   = pat;
            cmd.k     = want_k;
            cmd.extra = x_byte;
            fc_new    = {1'b0, fc_reg} + {14'd0, want};
            if (fc_new > {1'b0, cfg.max_frame_bytes}) begin
                // limit may have dropped below the count mid-frame
                cmd.nb   = (fc_reg >= cfg.max_frame_bytes) ? 3'd0
                                                            : 3'(cfg.max_frame_bytes - fc_reg);
                cmd.term = cfd_pkg::RK_ABORT;
                cmd.err  = cfd_pkg::ERR_OVERLEN;
                clr      = 1'b1;
            end else begin
                cmd.nb  = want;
                fc_next = fc_new[15:0];
                case (after)
                    cfd_pkg::AF_LEN: begin
                        if (le) begin
                            case (lbs_in[1:0])
                                2'd0: lacc_new = lacc_in | {24'd0, in_byte};
                                2'd1: lacc_new = lacc_in | {16'd0, in_byte, 8'd0};
                                2'd2: lacc_new = lacc_in | {8'd0, in_byte, 16'd0};
                                default: lacc_new = lacc_in | {in_byte, 24'd0};
                            endcase
                        end else begin
                            lacc_new = {lacc_in[23:0], in_byte};
                        end
                        lbs_new = lbs_in + 3'd1;
                        if (lbs_new < ls) begin
                            lbs_next  = lbs_new;
                            lacc_next = lacc_new;
                        end else begin
                            lbs_next  = '0;
                            lacc_next = '0;
                            if (lacc_new > {16'd0, cfg.max_frame_bytes}) begin
                                cmd.term = cfd_pkg::RK_ABORT;
                                cmd.err  = cfd_pkg::ERR_BADLEN;
                                clr      = 1'b1;
                            end else begin
                                exp_next = lacc_new[15:0];
                                if (ec != '0) begin
                                    phase_next = cfd_pkg::PH_AWAIT_END;
                                end else if (lacc_new == '0) begin
                                    cmd.term = cfd_pkg::RK_DONE;
                                    clr      = 1'b1;
                                end else begin
                                    phase_next = cfd_pkg::PH_IN_FRAME;
                                end
                            end
                        end
                    end
                    cfd_pkg::AF_CHK: begin
                        if (ec == '0 && exp_reg != '0 &&
                            fc_new >= {9'd0, off} + {14'd0, ls} + {1'b0, exp_reg}) begin
                            cmd.term = cfd_pkg::RK_DONE;
                            clr      = 1'b1;
                        end
                    end
                    cfd_pkg::AF_DONE: begin
                        cmd.term = cfd_pkg::RK_DONE;
                        clr      = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        if (clr) begin
            phase_next = cfd_pkg::PH_IDLE;
            smp_next   = '0;
            emp_next   = '0;
            fc_next    = '0;
            lbs_next   = '0;
            lacc_next  = '0;
            exp_next   = '0;
            itc_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cfd_pkg::PH_IDLE;
            smp_reg   <= '0;
            emp_reg   <= '0;
            fc_reg    <= '0;
            lbs_reg   <= '0;
            lacc_reg  <= '0;
            exp_reg   <= '0;
            itc_reg   <= '0;
        end else if (acc) begin
            phase_reg <= phase_next;
            smp_reg   <= smp_next;
            emp_reg   <= emp_next;
            fc_reg    <= fc_next;
            lbs_reg   <= lbs_next;
            lacc_reg  <= lacc_next;
            exp_reg   <= exp_next;
            itc_reg   <= itc_next;
        end
    end

endmodule

// ===== sv/cfd_queue.sv =====
module cfd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cfd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output cfd_pkg::cmd_t head
);

    localparam int PW = $clog2(cfd_pkg::QUEUE_DEPTH);

    cfd_pkg::cmd_t mem [cfd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(cfd_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == PW'(cfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == PW'(cfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== sv/cfd_back.sv =====
module cfd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          empty,
    input  cfd_pkg::cmd_t head,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    logic [2:0]  idx_reg;
    logic        vld_reg;
    logic [1:0]  kind_reg, err_reg;
    logic [7:0]  byte_reg;
    logic [15:0] len_reg;
    logic        last_reg;

    logic        load, is_last;
    logic [2:0]  total;
    logic [1:0]  r_kind, r_err;
    logic [7:0]  r_byte;
    logic [15:0] r_len;

    assign total   = head.nb + {2'd0, head.term != cfd_pkg::RK_BYTE};
    assign is_last = (idx_reg == total - 3'd1);
    assign load    = !empty && (!vld_reg || m_tready);
    assign pop     = load && is_last;

    always_comb begin
        if (idx_reg < head.nb) begin
            r_kind = cfd_pkg::RK_BYTE;
            r_byte = (idx_reg < head.k) ? cfd_pkg::pat_byte(head.pat, idx_reg[1:0])
                                        : head.extra;
            r_err  = cfd_pkg::ERR_NONE;
            r_len  = head.base + {13'd0, idx_reg} + 16'd1;
        end else begin
            r_kind = head.term;
            r_byte = '0;
            r_err  = head.err;
            r_len  = head.base + {13'd0, head.nb};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (load) begin
                vld_reg <= 1'b1;
                idx_reg <= is_last ? 3'd0 : idx_reg + 3'd1;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= r_kind;
            byte_reg <= r_byte;
            err_reg  <= r_err;
            len_reg  <= r_len;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {6'd0, len_reg, err_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
